/* hdl/histogram_bayes_posterior_defines.svh */
// assertion macros for the histogram bayes posterior block
`ifndef HISTOGRAM_BAYES_POSTERIOR_DEFINES_SVH
`define HISTOGRAM_BAYES_POSTERIOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication check
`define HBP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication check
`define HBP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define HBP_ASSERT_IMP(label, clk, rstn, ante, cons)
`define HBP_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

/* hdl/hbp_pkg.sv */
// constants, types and helpers for the histogram bayes posterior block
package hbp_pkg;

    // table geometry
    localparam int MAX_CUES    = 8;
    localparam int IDX_W       = MAX_CUES;
    localparam int TABLE_DEPTH = 1 << MAX_CUES;
    localparam int CUE_FIELD_W = 8;
    localparam int CUES_W      = 4;
    localparam logic [CUES_W-1:0] CUES_RESET = CUES_W'(8);

    // count storage
    localparam int COUNT_WIDTH = 32;
    typedef logic [COUNT_WIDTH-1:0] count_t;
    localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // fixed point
    localparam int Q_W = 17;
    typedef logic [Q_W-1:0] q16_t;
    localparam q16_t ONE_Q16 = 17'h10000;
    localparam int DIV_W     = 33;
    localparam int PROD_W    = 2 * Q_W;
    localparam logic [PROD_W-1:0] DENOM_MIN = PROD_W'(4295);
    localparam int DIV_STEPS = Q_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // stream payload widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    // operation codes
    localparam logic OP_TRAIN = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // saturating counter increment
    function automatic count_t sat_inc(input count_t v);
        return (v == COUNT_MAX) ? v : v + count_t'(1);
    endfunction

    // clamp a quotient to one in Q1.16
    function automatic q16_t q_clamp(input q16_t q);
        return (q > ONE_Q16) ? ONE_Q16 : q;
    endfunction

endpackage

/* hdl/histogram_bayes_posterior.sv */
// naive bayes cue fusion over two count tables with a shared iterative divider
// a query reads the tables, then runs two likelihood divisions, two products, a fallback check
// and the posterior division, which the prior fallback skips; one item is in flight at a time,
// as three 17-step divisions and two products share one divider and one 17x17 multiplier
// reset: synchronous active-low aresetn, then a pass over all 256 entries clears both count
// memories while s_tready stays low; configuration writes are taken throughout
`include "histogram_bayes_posterior_defines.svh"

module histogram_bayes_posterior (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [hbp_pkg::CUES_W-1:0]    cfg_wr_data,   // cues_in_use
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hbp_pkg::S_TDATA_W-1:0] s_tdata,       // cue_bits[7:0], door_present[8], prior[25:9]
    input  logic [0:0]                    s_tuser,       // operation[0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hbp_pkg::M_TDATA_W-1:0] m_tdata,       // posterior[16:0]
    output logic [0:0]                    m_tuser        // used_prior[0]
);

    // sequencer states
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_LOOK   = 4'd2;
    localparam logic [3:0] S_DIV_T  = 4'd3;
    localparam logic [3:0] S_DIV_F  = 4'd4;
    localparam logic [3:0] S_MUL_T  = 4'd5;
    localparam logic [3:0] S_MUL_F  = 4'd6;
    localparam logic [3:0] S_CHECK  = 4'd7;
    localparam logic [3:0] S_DIV_P  = 4'd8;
    localparam logic [3:0] S_RESULT = 4'd9;

    localparam int QW = hbp_pkg::Q_W;
    localparam int DW = hbp_pkg::DIV_W;
    localparam int PW = hbp_pkg::PROD_W;
    localparam logic [hbp_pkg::STEP_W-1:0] DIV_LAST = hbp_pkg::STEP_W'(hbp_pkg::DIV_STEPS - 1);

    logic [3:0] state_reg, state_next;
    logic [hbp_pkg::CUES_W-1:0] cues_reg;
    logic [hbp_pkg::IDX_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic op_reg, op_next;
    logic label_reg, label_next;
    hbp_pkg::q16_t prior_reg, prior_next;
    logic [hbp_pkg::IDX_W-1:0] addr_reg, addr_next;

    hbp_pkg::count_t pos_mem [hbp_pkg::TABLE_DEPTH];
    hbp_pkg::count_t neg_mem [hbp_pkg::TABLE_DEPTH];
    hbp_pkg::count_t pos_rd_reg, neg_rd_reg;
    hbp_pkg::count_t pos_total_reg, pos_total_next;
    hbp_pkg::count_t neg_total_reg, neg_total_next;

    logic [DW-1:0] div_rem_reg, div_rem_next;
    logic          div_bit_reg, div_bit_next;
    logic [DW-1:0] div_d_reg, div_d_next;
    hbp_pkg::q16_t div_quo_reg, div_quo_next;
    logic [hbp_pkg::STEP_W-1:0] div_cnt_reg, div_cnt_next;

    hbp_pkg::q16_t lt_reg, lt_next;
    hbp_pkg::q16_t lf_reg, lf_next;
    logic [PW-1:0] mul_reg, mul_next;
    logic [DW-1:0] num_reg, num_next;

    hbp_pkg::q16_t res_post_reg, res_post_next;
    logic          res_used_reg, res_used_next;
    logic          m_valid_reg, m_valid_next;
    hbp_pkg::q16_t m_post_reg, m_post_next;
    logic          m_used_reg, m_used_next;

    // input field decode
    logic [hbp_pkg::CUE_FIELD_W-1:0] in_cues;
    logic                            in_label;
    hbp_pkg::q16_t                   in_prior;
    logic                            in_op;
    logic [hbp_pkg::IDX_W-1:0]       cue_mask;
    logic [hbp_pkg::IDX_W-1:0]       in_idx;
    logic                            in_accept;

    assign in_cues   = s_tdata[hbp_pkg::CUE_FIELD_W-1:0];
    assign in_label  = s_tdata[hbp_pkg::CUE_FIELD_W];
    assign in_prior  = s_tdata[hbp_pkg::CUE_FIELD_W+QW:hbp_pkg::CUE_FIELD_W+1];
    assign in_op     = s_tuser[0];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // index mask from the number of cues in use, counts above the maximum use all bits
    always_comb begin
        for (int i = 0; i < hbp_pkg::IDX_W; i++) begin
            cue_mask[i] = (hbp_pkg::CUES_W'(i) < cues_reg);
        end
    end
    assign in_idx = in_cues[hbp_pkg::IDX_W-1:0] & cue_mask;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cues_reg <= hbp_pkg::CUES_RESET;
        end else if (cfg_wr_en) begin
            cues_reg <= cfg_wr_data;
        end
    end

    // count memory write port shared by the clearing pass and training updates
    logic                      clearing;
    logic                      train_look;
    logic                      pos_we, neg_we;
    logic [hbp_pkg::IDX_W-1:0] mem_wr_addr;
    hbp_pkg::count_t           pos_wr_data, neg_wr_data;

    assign clearing    = (state_reg == S_CLEAR);
    assign train_look  = (state_reg == S_LOOK) && (op_reg == hbp_pkg::OP_TRAIN);
    assign pos_we      = clearing || (train_look && label_reg);
    assign neg_we      = clearing || (train_look && !label_reg);
    assign mem_wr_addr = clearing ? clr_cnt_reg : addr_reg;
    assign pos_wr_data = clearing ? '0 : hbp_pkg::sat_inc(pos_rd_reg);
    assign neg_wr_data = clearing ? '0 : hbp_pkg::sat_inc(neg_rd_reg);

    // count memories, registered read at transaction accept
    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[mem_wr_addr] <= pos_wr_data;
        end
        if (neg_we) begin
            neg_mem[mem_wr_addr] <= neg_wr_data;
        end
        if (in_accept) begin
            pos_rd_reg <= pos_mem[in_idx];
            neg_rd_reg <= neg_mem[in_idx];
        end
    end

    // shared restoring divider step, one quotient bit per cycle
    logic [DW:0]   div_trial;
    logic [DW:0]   div_diff;
    logic          div_ge;
    logic          div_last;
    hbp_pkg::q16_t div_quo_step;

    assign div_trial    = {div_rem_reg, div_bit_reg};
    assign div_diff     = div_trial - {1'b0, div_d_reg};
    assign div_ge       = (div_trial >= {1'b0, div_d_reg});
    assign div_last     = (div_cnt_reg == DIV_LAST);
    assign div_quo_step = {div_quo_reg[QW-2:0], div_ge};

    // shared multiplier, prior times positive then complement times negative likelihood
    hbp_pkg::q16_t mul_a, mul_b;
    logic [PW-1:0] mul_prod;
    logic [PW-1:0] den_sum;
    logic          den_small;

    assign mul_a     = (state_reg == S_MUL_T) ? prior_reg : hbp_pkg::ONE_Q16 - prior_reg;
    assign mul_b     = (state_reg == S_MUL_T) ? lt_reg : lf_reg;
    assign mul_prod  = {{QW{1'b0}}, mul_a} * {{QW{1'b0}}, mul_b};
    assign den_sum   = PW'(num_reg) + mul_reg;
    assign den_small = (den_sum < hbp_pkg::DENOM_MIN);

    // sequencer and datapath next state
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        op_next        = op_reg;
        label_next     = label_reg;
        prior_next     = prior_reg;
        addr_next      = addr_reg;
        pos_total_next = pos_total_reg;
        neg_total_next = neg_total_reg;
        div_rem_next   = div_rem_reg;
        div_bit_next   = div_bit_reg;
        div_d_next     = div_d_reg;
        div_quo_next   = div_quo_reg;
        div_cnt_next   = div_cnt_reg;
        lt_next        = lt_reg;
        lf_next        = lf_reg;
        mul_next       = mul_reg;
        num_next       = num_reg;
        res_post_next  = res_post_reg;
        res_used_next  = res_used_reg;
        m_valid_next   = m_valid_reg;
        m_post_next    = m_post_reg;
        m_used_next    = m_used_reg;

        // output register drains on a result transaction
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // divider advances in every division state
        if (state_reg == S_DIV_T || state_reg == S_DIV_F || state_reg == S_DIV_P) begin
            div_rem_next = div_ge ? div_diff[DW-1:0] : div_trial[DW-1:0];
            div_bit_next = 1'b0;
            div_quo_next = div_quo_step;
            div_cnt_next = div_cnt_reg + hbp_pkg::STEP_W'(1);
        end

        case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + hbp_pkg::IDX_W'(1);
                if (clr_cnt_reg == hbp_pkg::IDX_W'(hbp_pkg::TABLE_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    op_next    = in_op;
                    label_next = in_label;
                    prior_next = hbp_pkg::q_clamp(in_prior);
                    addr_next  = in_idx;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                if (op_reg == hbp_pkg::OP_TRAIN) begin
                    if (label_reg) begin
                        pos_total_next = hbp_pkg::sat_inc(pos_total_reg);
                    end else begin
                        neg_total_next = hbp_pkg::sat_inc(neg_total_reg);
                    end
                    state_next = S_IDLE;
                end else begin
                    div_rem_next = DW'(pos_rd_reg >> 1);
                    div_bit_next = pos_rd_reg[0];
                    div_d_next   = DW'(pos_total_reg);
                    div_quo_next = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIV_T;
                end
            end
            S_DIV_T: begin
                if (div_last) begin
                    lt_next      = (pos_total_reg == '0) ? '0 : hbp_pkg::q_clamp(div_quo_step);
                    div_rem_next = DW'(neg_rd_reg >> 1);
                    div_bit_next = neg_rd_reg[0];
                    div_d_next   = DW'(neg_total_reg);
                    div_quo_next = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIV_F;
                end
            end
            S_DIV_F: begin
                if (div_last) begin
                    lf_next    = (neg_total_reg == '0) ? '0 : hbp_pkg::q_clamp(div_quo_step);
                    state_next = S_MUL_T;
                end
            end
            S_MUL_T: begin
                mul_next   = mul_prod;
                state_next = S_MUL_F;
            end
            S_MUL_F: begin
                num_next   = DW'(mul_reg);
                mul_next   = mul_prod;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (den_small) begin
                    res_post_next = prior_reg;
                    res_used_next = 1'b1;
                    state_next    = S_RESULT;
                end else begin
                    div_rem_next  = {1'b0, num_reg[DW-1:1]};
                    div_bit_next  = num_reg[0];
                    div_d_next    = den_sum[DW-1:0];
                    div_quo_next  = '0;
                    div_cnt_next  = '0;
                    res_used_next = 1'b0;
                    state_next    = S_DIV_P;
                end
            end
            S_DIV_P: begin
                if (div_last) begin
                    res_post_next = hbp_pkg::q_clamp(div_quo_step);
                    state_next    = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_post_next  = res_post_reg;
                    m_used_next  = res_used_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            pos_total_reg <= '0;
            neg_total_reg <= '0;
            div_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pos_total_reg <= pos_total_next;
            neg_total_reg <= neg_total_next;
            div_cnt_reg   <= div_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        label_reg    <= label_next;
        prior_reg    <= prior_next;
        addr_reg     <= addr_next;
        div_rem_reg  <= div_rem_next;
        div_bit_reg  <= div_bit_next;
        div_d_reg    <= div_d_next;
        div_quo_reg  <= div_quo_next;
        lt_reg       <= lt_next;
        lf_reg       <= lf_next;
        mul_reg      <= mul_next;
        num_reg      <= num_next;
        res_post_reg <= res_post_next;
        res_used_reg <= res_used_next;
        m_post_reg   <= m_post_next;
        m_used_reg   <= m_used_next;
    end

    // result channel
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = hbp_pkg::M_TDATA_W'(m_post_reg);
    assign m_tuser  = m_used_reg;

    // checks
    `HBP_ASSERT_IMP(a_post_range, aclk, aresetn, m_valid_reg, m_post_reg <= hbp_pkg::ONE_Q16)
    `HBP_ASSERT_IMP(a_div_count, aclk, aresetn, state_reg == S_DIV_P, div_cnt_reg <= DIV_LAST)
    `HBP_ASSERT_NEXT(a_train_silent, aclk, aresetn, train_look, !$rose(m_valid_reg))

endmodule

/* tb/histogram_bayes_posterior_tb.sv */
// self-checking testbench for the histogram bayes posterior block
`timescale 1ns / 1ps

module histogram_bayes_posterior_tb;
    import hbp_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASE_ITEMS = 240;
    localparam int POOL_SIZE = 6;

    typedef struct packed {
        logic       op;
        logic [7:0] cues;
        logic       door;
        q16_t       prior;
    } cue_item_t;

    typedef struct packed {
        q16_t posterior;
        logic used_prior;
    } posterior_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CUES_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    // model state: configuration copy and the two histograms
    logic [CUES_W-1:0] cues_cfg = CUES_RESET;
    count_t            pos_hist [TABLE_DEPTH] = '{default: '0};
    count_t            neg_hist [TABLE_DEPTH] = '{default: '0};
    count_t            pos_sum = '0;
    count_t            neg_sum = '0;

    cue_item_t  pending_q [$];
    posterior_t posterior_q [$];
    cue_item_t  in_flight;
    int         fail_count = 0;
    int         quiet_cycles = 0;
    int         src_gap_pct = 22;
    int         sink_stall_pct = 48;
    logic [7:0] cue_pool [POOL_SIZE];
    int         door_bias [POOL_SIZE];

    histogram_bayes_posterior dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // likelihood in Q1.16, zero for an empty histogram
    function automatic longint unsigned ratio_q16(input count_t cnt, input count_t total);
        longint unsigned q;
        if (total == '0)
            return 0;
        q = (longint'(cnt) << 16) / longint'(total);
        return (q > ONE_Q16) ? longint'(ONE_Q16) : q;
    endfunction

    // update the histograms or compute the expected posterior
    task automatic fuse_item(input cue_item_t it);
        int unsigned     n;
        logic [8:0]      mask;
        logic [7:0]      idx;
        longint unsigned p, lt, lf, num, den, post;
        posterior_t      r;
        n = (cues_cfg > MAX_CUES) ? MAX_CUES : cues_cfg;
        mask = (9'd1 << n) - 9'd1;
        idx = it.cues & mask[7:0];
        if (it.op == OP_TRAIN) begin
            if (it.door) begin
                if (pos_hist[idx] != COUNT_MAX) pos_hist[idx] = pos_hist[idx] + 1'b1;
                if (pos_sum != COUNT_MAX) pos_sum = pos_sum + 1'b1;
            end else begin
                if (neg_hist[idx] != COUNT_MAX) neg_hist[idx] = neg_hist[idx] + 1'b1;
                if (neg_sum != COUNT_MAX) neg_sum = neg_sum + 1'b1;
            end
            return;
        end
        // prior above one is clamped before use
        p = (it.prior > ONE_Q16) ? longint'(ONE_Q16) : longint'(it.prior);
        lt = ratio_q16(pos_hist[idx], pos_sum);
        lf = ratio_q16(neg_hist[idx], neg_sum);
        num = p * lt;
        den = num + (longint'(ONE_Q16) - p) * lf;
        if (den < longint'(DENOM_MIN)) begin
            r.posterior = q16_t'(p);
            r.used_prior = 1'b1;
        end else begin
            post = (num << 16) / den;
            if (post > ONE_Q16)
                post = ONE_Q16;
            r.posterior = q16_t'(post);
            r.used_prior = 1'b0;
        end
        posterior_q.push_back(r);
    endtask

    function automatic void push_item(input logic op, input logic [7:0] cues,
                                      input logic door, input q16_t prior);
        cue_item_t it;
        it.op = op;
        it.cues = cues;
        it.door = door;
        it.prior = prior;
        pending_q.push_back(it);
    endfunction

    // mostly recurring cue patterns so queries hit trained bins
    function automatic cue_item_t rand_cue_item();
        cue_item_t it;
        int        slot;
        int        pick;
        slot = $urandom_range(0, POOL_SIZE - 1);
        it.op = ($urandom_range(0, 99) < 45) ? OP_QUERY : OP_TRAIN;
        if ($urandom_range(0, 99) < 75)
            it.cues = cue_pool[slot];
        else
            it.cues = 8'($urandom_range(0, 255));
        if (it.op == OP_TRAIN)
            it.door = ($urandom_range(0, 99) < door_bias[slot]);
        else
            it.door = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (it.op == OP_TRAIN || pick < 10)
            it.prior = q16_t'($urandom_range(0, 131071));
        else if (pick < 15)
            it.prior = '0;
        else if (pick < 20)
            it.prior = ONE_Q16;
        else if (pick < 30)
            it.prior = q16_t'($urandom_range(0, 64));
        else
            it.prior = q16_t'($urandom_range(0, 65536));
        return it;
    endfunction

    // wait until every transaction is in and every result is out
    task automatic drain_block();
        while (pending_q.size() != 0 || s_tvalid || posterior_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cues(input logic [CUES_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        cues_cfg = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // input driver
    always @(posedge aclk) begin
        logic fire;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            fire = s_tvalid && s_tready;
            if (fire)
                fuse_item(in_flight);
            if (!s_tvalid || fire) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= src_gap_pct) begin
                    in_flight = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'b0, in_flight.prior, in_flight.door, in_flight.cues};
                    s_tuser <= in_flight.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and ready generation
    always @(posedge aclk) begin
        posterior_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (posterior_q.size() == 0) begin
                    $display("%0t: unexpected result posterior %0d used_prior %0d",
                             $time, m_tdata[Q_W-1:0], m_tuser[0]);
                    fail_count++;
                end else begin
                    want = posterior_q.pop_front();
                    if (m_tdata[Q_W-1:0] !== want.posterior) begin
                        $display("%0t: posterior mismatch: expected %0d, actual %0d",
                                 $time, want.posterior, m_tdata[Q_W-1:0]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.used_prior) begin
                        $display("%0t: used_prior mismatch: expected %0d, actual %0d",
                                 $time, want.used_prior, m_tuser[0]);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("histogram_bayes_posterior_tb NOT OK");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        logic [CUES_W-1:0] cue_plan [6];
        int ph, k, j;
        cue_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd12};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty tables, prior extremes, opposing labels, reset width of 8
        push_item(OP_QUERY, 8'h00, 1'b1, 17'd0);
        push_item(OP_QUERY, 8'hFF, 1'b0, ONE_Q16);
        push_item(OP_QUERY, 8'hA5, 1'b1, 17'h1FFFF);
        push_item(OP_TRAIN, 8'hFF, 1'b1, 17'h1FFFF);
        push_item(OP_TRAIN, 8'h00, 1'b0, 17'd0);
        push_item(OP_TRAIN, 8'h00, 1'b1, 17'd0);
        push_item(OP_TRAIN, 8'hFF, 1'b0, 17'd12345);
        push_item(OP_TRAIN, 8'hFF, 1'b1, ONE_Q16);
        push_item(OP_QUERY, 8'hFF, 1'b0, 17'd32768);
        push_item(OP_QUERY, 8'h00, 1'b1, 17'd0);
        push_item(OP_QUERY, 8'h00, 1'b0, ONE_Q16);
        push_item(OP_QUERY, 8'hFF, 1'b1, 17'd1);
        push_item(OP_QUERY, 8'h5A, 1'b0, 17'd40000);
        push_item(OP_QUERY, 8'hFF, 1'b0, 17'h1FFFF);
        push_item(OP_TRAIN, 8'h5A, 1'b0, ONE_Q16);
        push_item(OP_QUERY, 8'h5A, 1'b1, 17'd65535);
        push_item(OP_QUERY, 8'h5A, 1'b0, 17'd1);
        drain_block();

        // random phases over several index widths
        for (ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                src_gap_pct = 48;
                sink_stall_pct = 22;
            end else if (ph == 4) begin
                src_gap_pct = 0;
                sink_stall_pct = 0;
            end
            write_cues(cue_plan[ph]);
            for (j = 0; j < POOL_SIZE; j++) begin
                cue_pool[j] = 8'($urandom_range(0, 255));
                door_bias[j] = $urandom_range(0, 100);
            end
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // hold the source once mid-phase until all results are back
                if (k == PHASE_ITEMS / 2)
                    drain_block();
                pending_q.push_back(rand_cue_item());
            end
            drain_block();
        end

        if (fail_count == 0) begin
            $display("histogram_bayes_posterior_tb OK");
        end else begin
            $display("histogram_bayes_posterior_tb NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/hbp_pkg.sv
hdl/histogram_bayes_posterior.sv
tb/histogram_bayes_posterior_tb.sv
